/* src/emr_pkg.sv */
// shared types, constants and helpers for the eller maze row generator
package emr_pkg;

  localparam int MaxColumns = 32;
  localparam int LabelW     = 5;
  localparam int ColW       = $clog2(MaxColumns);
  localparam int WidthW     = 6;
  localparam int RightW     = 31;
  localparam int DownW      = 32;
  localparam int WidthLimit = (MaxColumns > 32) ? 32 : MaxColumns;

  typedef logic [LabelW-1:0] label_t;
  typedef logic [ColW-1:0]   col_t;
  typedef logic [WidthW-1:0] width_t;

  typedef struct packed {
    logic [RightW-1:0] right_random;
    logic [DownW-1:0]  down_random;
    logic              last_row;
  } in_word_t;

  typedef struct packed {
    logic [RightW-1:0] right_open;
    logic [DownW-1:0]  down_open;
  } out_word_t;

  // one cell of the label ring: set label plus the column it belongs to
  typedef struct packed {
    label_t label;
    col_t   col;
  } cell_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic   shift;
    logic   relabel;
    label_t from_label;
    label_t to_label;
    logic   to_index;
    width_t width;
  } ring_cmd_t;

  typedef struct packed {
    logic   busy;
    width_t width;
  } emr_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MERGE,
    ST_DOWN,
    ST_FILL,
    ST_EMIT
  } emr_state_t;

  // smallest label not in the used set, stopping at the top label
  function automatic label_t first_free(input logic [DownW-1:0] used);
    label_t c;
    c = label_t'(LabelW'(31));
    for (int i = 30; i >= 0; i--) begin
      if (!used[i]) c = label_t'(i);
    end
    return c;
  endfunction

endpackage

/* src/emr_cell.sv */
// one cell of the label ring: holds a column label and passes it to its neighbor
module emr_cell (
  input  logic              clk,
  input  logic              rst,
  input  emr_pkg::col_t     home,
  input  emr_pkg::cell_t    shift_in,
  input  emr_pkg::ring_cmd_t cmd,
  output emr_pkg::cell_t    cur,
  output emr_pkg::cell_t    fwd
);
  import emr_pkg::*;

  cell_t q;
  logic  in_use;

  assign in_use = {1'b0, q.col} < cmd.width;
  assign cur    = q;

  always_comb begin
    fwd = q;
    if (cmd.relabel && in_use && (q.label == cmd.from_label)) begin
      fwd.label = cmd.to_label;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.label <= label_t'(home);
      q.col   <= home;
    end else if (cmd.to_index) begin
      q.label <= label_t'(q.col);
    end else if (cmd.shift) begin
      q <= shift_in;
    end
  end

endmodule

/* src/emr_ctrl.sv */
// sequencer: item handshake, merge / down / fill passes over the ring, result register
module emr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  emr_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output emr_pkg::out_word_t  out_data,
  input  emr_pkg::width_t     row_width,
  input  emr_pkg::cell_t      head0,
  input  emr_pkg::cell_t      head1,
  input  emr_pkg::cell_t      head0_fwd,
  output emr_pkg::ring_cmd_t  cmd,
  output emr_pkg::cell_t      tail_in,
  output emr_pkg::emr_status_t status
);
  import emr_pkg::*;

  emr_state_t state, state_next;
  col_t       step, step_next;
  in_word_t   item, item_next;
  logic [DownW-1:0] ro, ro_next;
  logic [DownW-1:0] dn, dn_next;
  logic [DownW-1:0] used, used_next;
  logic       out_load;
  logic       out_valid_next;
  out_word_t  out_next;

  width_t     w;
  logic       step_last;
  logic       col_ok;
  logic       pair_ok;
  logic       col_last;
  logic       merge_req;
  logic       merge_hit;
  logic       down_open;
  label_t     free_label;
  logic [DownW-1:0] right_ext;

  always_comb begin
    if (row_width < width_t'(2)) begin
      w = width_t'(2);
    end else if (row_width > width_t'(WidthLimit)) begin
      w = width_t'(WidthLimit);
    end else begin
      w = row_width;
    end
  end

  assign step_last  = step == col_t'(MaxColumns - 1);
  assign col_ok     = {1'b0, step} < w;
  assign pair_ok    = ({1'b0, step} + width_t'(1)) < w;
  assign col_last   = ({1'b0, step} + width_t'(1)) == w;
  assign right_ext  = {1'b0, item.right_random};
  assign merge_req  = item.last_row || right_ext[step];
  assign merge_hit  = pair_ok && merge_req && (head0.label != head1.label);
  assign down_open  = item.down_random[step] || col_last || (head0.label != head1.label);
  assign free_label = first_free(used);
  assign out_load   = (state == ST_EMIT) && (!out_valid || !out_stall);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MERGE;
      end
      ST_MERGE: begin
        if (step_last) state_next = item.last_row ? ST_EMIT : ST_DOWN;
      end
      ST_DOWN: begin
        if (step_last) state_next = ST_FILL;
      end
      ST_FILL: begin
        if (step_last) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall       = 1'b1;
    cmd            = '0;
    cmd.width      = w;
    cmd.from_label = head1.label;
    cmd.to_label   = head0.label;
    tail_in        = head0_fwd;
    step_next      = step;
    item_next      = item;
    ro_next        = ro;
    dn_next        = dn;
    used_next      = used;
    out_next       = out_data;
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        if (in_valid) begin
          item_next = in_data;
          step_next = '0;
          ro_next   = '0;
          dn_next   = '0;
          used_next = '0;
        end
      end
      ST_MERGE: begin
        cmd.shift   = 1'b1;
        cmd.relabel = merge_hit;
        step_next   = step + col_t'(1);
        if (merge_hit) ro_next[step] = 1'b1;
      end
      ST_DOWN: begin
        cmd.shift = 1'b1;
        step_next = step + col_t'(1);
        if (col_ok && down_open) begin
          dn_next[step]           = 1'b1;
          used_next[head0.label]  = 1'b1;
        end
      end
      ST_FILL: begin
        cmd.shift = 1'b1;
        step_next = step + col_t'(1);
        if (col_ok && !dn[step]) begin
          tail_in.label         = free_label;
          used_next[free_label] = 1'b1;
        end
      end
      ST_EMIT: begin
        cmd.to_index = item.last_row;
        if (out_load) begin
          out_valid_next      = 1'b1;
          out_next.right_open = ro[RightW-1:0];
          out_next.down_open  = item.last_row ? '0 : dn;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign status.busy  = state != ST_IDLE;
  assign status.width = w;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    item     <= item_next;
    ro       <= ro_next;
    dn       <= dn_next;
    used     <= used_next;
    out_data <= out_next;
  end

endmodule

/* src/eller_maze_row_generator_top.sv */
// top level of the eller maze row generator: width register, label ring, sequencer
//
// one input word is one maze row: right_random asks for right walls to open,
// down_random asks for down walls to open, last_row closes the maze off.
// one output word comes back per input word: the walls that were removed.
// input and output use valid / stall; a word moves on an edge with valid high
// and stall low. cfg_wr_en / cfg_wr_data write row_width (columns in use);
// write it only while no row is in flight.
// the per-column set labels live in a ring of 32 cells that rotates one place
// per cycle during each pass, so the head of the ring sees each column pair in turn:
//   merge pass, down-wall pass, new-set fill pass, then emit
// a last row skips the down-wall and fill passes; the next row is taken the cycle
// after the result is registered, so no new row is accepted while one is in progress.
// a stalled result waits in the output register; the block then holds in emit.
// reset clears control state, sets row_width to 32 and labels to column index.
module eller_maze_row_generator_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  emr_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output emr_pkg::out_word_t out_data,
  input  logic               cfg_wr_en,
  input  emr_pkg::width_t    cfg_wr_data
);
  import emr_pkg::*;

  // width register, raw value; clamping happens in the sequencer
  width_t      row_width;

  // ring wiring: cur is each cell's stored word, fwd the word after relabel
  cell_t       ring_cur [MaxColumns];
  cell_t       ring_fwd [MaxColumns];
  cell_t       tail_in;
  ring_cmd_t   cmd;
  emr_status_t status;
  logic        ring_home;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= width_t'(32);
    end else if (cfg_wr_en) begin
      row_width <= cfg_wr_data;
    end
  end

  // cell i loads from cell i+1; the last cell loads from the sequencer,
  // which feeds back the head word or a freshly numbered set
  for (genvar i = 0; i < MaxColumns; i++) begin : g_ring
    if (i == MaxColumns - 1) begin : g_tail
      emr_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .home     (col_t'(i)),
        .shift_in (tail_in),
        .cmd      (cmd),
        .cur      (ring_cur[i]),
        .fwd      (ring_fwd[i])
      );
    end else begin : g_body
      emr_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .home     (col_t'(i)),
        .shift_in (ring_fwd[i+1]),
        .cmd      (cmd),
        .cur      (ring_cur[i]),
        .fwd      (ring_fwd[i])
      );
    end
  end

  emr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .row_width (row_width),
    .head0     (ring_cur[0]),
    .head1     (ring_cur[1]),
    .head0_fwd (ring_fwd[0]),
    .cmd       (cmd),
    .tail_in   (tail_in),
    .status    (status)
  );

  // every pass is a full rotation, so between rows each column sits at home
  always_comb begin
    ring_home = 1'b1;
    for (int i = 0; i < MaxColumns; i++) begin
      if (ring_cur[i].col != col_t'(i)) ring_home = 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_ring_home: assert property (@(posedge clk) disable iff (rst)
    !status.busy |-> ring_home)
    else $error("label ring not aligned while idle");

  a_down_in_width: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.down_open >> status.width) == '0)
    else $error("down wall opened beyond the columns in use");

  a_right_in_width: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.right_open >> (status.width - width_t'(1))) == '0)
    else $error("right wall opened beyond the columns in use");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> status.busy)
    else $error("accepted row did not start the passes");
`endif

endmodule
